// ===== rtl/csrt_pkg.sv =====
// ----------------------------------------------------------------------------
// csrt_pkg
// Shared types and constants of the clock skew regression table.
// ----------------------------------------------------------------------------
package csrt_pkg;

	localparam int TIME_W   = 32;
	localparam int LIMIT_W  = 31;
	localparam int CNTLIM_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int FRAC_W   = 30;

	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_COUNT_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ENTRY_LIMIT  = 2'd2;

	localparam logic [LIMIT_W-1:0]  RST_ERROR_LIMIT       = 31'd1000;
	localparam logic [CNTLIM_W-1:0] RST_ERROR_COUNT_LIMIT = 4'd5;
	localparam logic [CNTLIM_W-1:0] RST_SYNC_ENTRY_LIMIT  = 4'd4;
	localparam logic [CNTLIM_W-1:0] REJECT_MAX            = 4'd15;

	localparam logic [TIME_W-1:0] SKEW_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [TIME_W-1:0] SKEW_NEG_MAX = 32'h8000_0000;

	typedef struct packed {
		logic [TIME_W-1:0]        sample_local_time;
		logic signed [TIME_W-1:0] sample_offset;
	} sample_t;

	typedef struct packed {
		logic                     sample_accepted;
		logic                     table_cleared;
		logic [3:0]               stored_entries;
		logic                     synchronized;
		logic                     estimate_valid;
		logic signed [TIME_W-1:0] skew_estimate;
		logic signed [TIME_W-1:0] mean_offset;
		logic [TIME_W-1:0]        mean_local_time;
	} result_t;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic [TIME_W-1:0] offset;
	} entry_t;

endpackage

// ===== rtl/csrt_ram.sv =====
// ----------------------------------------------------------------------------
// csrt_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module csrt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/csrt_div.sv =====
// ----------------------------------------------------------------------------
// csrt_div
// Unsigned restoring divider, one quotient bit per cycle, sticky overflow
// for quotient bits above Q_W.
// ----------------------------------------------------------------------------
module csrt_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 8,
	parameter int Q_W   = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [Q_W-1:0]   quot,
	output logic             ovf,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [Q_W-1:0]   quot_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   partial;
	logic             ge;
	logic [DEN_W:0]   diff;

	assign partial = {rem_q, num_q[NUM_W-1]};
	assign ge      = partial >= {1'b0, den_q};
	assign diff    = partial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
			ovf_q  <= 1'b0;
		end else if (run_q) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			rem_q  <= ge ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
			quot_q <= {quot_q[Q_W-2:0], ge};
			ovf_q  <= ovf_q | quot_q[Q_W-1];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign ovf  = ovf_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/clock_skew_regression_table.sv =====
// ----------------------------------------------------------------------------
// clock_skew_regression_table
// Stores time-sync samples in a table and fits a least-squares line of
// offset versus local time; reports means, skew (Q2.30) and sync status.
// ----------------------------------------------------------------------------
//
//  channel   signals                              handshake
//  --------  -----------------------------------  ------------------------------
//  input     start, busy, sample                  item taken when start & !busy
//  result    done, result                         one-cycle strobe on done
//  config    cfg_we, cfg_index, cfg_wdata         written when cfg_we is high
//
// Flow: one item at a time. Busy lasts longer the more slots are filled and
//   longer still when the spread is nonzero and the slope divider runs; an
//   empty table goes straight to the result. Each filled slot runs the pair
//   of serial mean dividers side by side; the slope divider sets the tail.
// Reset: arst_n clears the filled-slot flags, counters, held skew and the
//   configuration registers to their defaults; the sample RAM needs no clearing.
// Stalls: busy stays high from the accepting edge until the done strobe; the
//   receiver cannot hold results off.
//
module clock_skew_regression_table
	import csrt_pkg::*;
#(
	parameter int TABLE_SLOTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  sample_t              sample,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]   cfg_wdata
);

	localparam int PTR_W = $clog2(TABLE_SLOTS);
	localparam int N_W   = $clog2(TABLE_SLOTS + 1);
	localparam int CMP_W = (N_W > CNTLIM_W) ? N_W : CNTLIM_W;
	localparam int ACC_W = 66 + PTR_W;
	localparam int SN_W  = ACC_W + FRAC_W;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(TABLE_SLOTS - 1);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_REF    = 5'd1;
	localparam logic [4:0] S_REF_W  = 5'd2;
	localparam logic [4:0] S_REF_L  = 5'd3;
	localparam logic [4:0] S_W1_SEL = 5'd4;
	localparam logic [4:0] S_W1_W   = 5'd5;
	localparam logic [4:0] S_W1_L   = 5'd6;
	localparam logic [4:0] S_W1_DIV = 5'd7;
	localparam logic [4:0] S_MEAN   = 5'd8;
	localparam logic [4:0] S_W2_SEL = 5'd9;
	localparam logic [4:0] S_W2_W   = 5'd10;
	localparam logic [4:0] S_W2_L   = 5'd11;
	localparam logic [4:0] S_W2_MA  = 5'd12;
	localparam logic [4:0] S_W2_MB  = 5'd13;
	localparam logic [4:0] S_W2_ACC = 5'd14;
	localparam logic [4:0] S_SKEW   = 5'd15;
	localparam logic [4:0] S_SLOPE  = 5'd16;
	localparam logic [4:0] S_SDIV   = 5'd17;

	// configuration registers
	logic [LIMIT_W-1:0]  err_lim_q;
	logic [CNTLIM_W-1:0] err_cnt_lim_q;
	logic [CNTLIM_W-1:0] sync_lim_q;

	// control state
	logic [4:0]             state_q;
	logic [TABLE_SLOTS-1:0] full_q;
	logic [N_W-1:0]         fill_q;
	logic [PTR_W-1:0]       ring_q;
	logic [CNTLIM_W-1:0]    rej_q;
	logic [TIME_W-1:0]      held_q;
	logic                   done_q;
	logic [PTR_W-1:0]       idx_q;
	logic [PTR_W-1:0]       addr_q;
	logic                   acc_q;
	logic                   clr_q;
	logic                   div_go_q;
	logic                   sdiv_go_q;

	// datapath registers
	logic [TIME_W-1:0]        ref_t_q, ref_o_q;
	logic [TIME_W-1:0]        qt_q, qo_q, rt_q, ro_q;
	logic                     neg_t_q, neg_o_q;
	logic [TIME_W-1:0]        mean_t_q, mean_o_q;
	logic signed [TIME_W-1:0] a_q, b_q;
	logic signed [63:0]       prod_s1;
	logic [ACC_W-1:0]         sxx_q;
	logic signed [ACC_W-1:0]  sxy_q;
	logic                     sxy_neg_q;
	logic [TIME_W-1:0]        num_t_q, num_o_q;
	logic [SN_W-1:0]          snum_q;
	result_t                  result_q;

	// combinational
	logic [PTR_W-1:0]   empty_idx;
	logic               any_empty;
	logic [PTR_W-1:0]   ref_idx;
	logic [PTR_W-1:0]   slot;
	logic [TIME_W-1:0]  abs_off;
	logic               reject;
	logic [CNTLIM_W-1:0] rej_inc;
	logic               accept_item;
	logic               ram_we;
	entry_t             ram_wdata, ram_rdata;
	logic [TIME_W-1:0]  dt, dof;
	logic               div_done;
	logic [TIME_W-1:0]  qt_div, qo_div;
	logic [N_W-1:0]     rt_div, ro_div;
	logic [TIME_W-1:0]  rt_fin, ro_fin;
	logic               sdiv_done;
	logic [TIME_W-1:0]  sq;
	logic               sovf;
	logic               last;
	logic signed [TIME_W-1:0] mul_y;
	logic [TIME_W-1:0]  skew_val;
	logic               sync_now;
	logic [ACC_W-1:0]   sxy_mag;

	assign accept_item = start && (state_q == S_IDLE);
	assign busy        = (state_q != S_IDLE);
	assign last        = (idx_q == LAST);

	// highest empty slot and lowest filled slot
	always_comb begin
		empty_idx = '0;
		any_empty = 1'b0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (!full_q[i]) begin
				empty_idx = PTR_W'(i);
				any_empty = 1'b1;
			end
		end
	end

	always_comb begin
		ref_idx = '0;
		for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
			if (full_q[i]) begin
				ref_idx = PTR_W'(i);
			end
		end
	end

	assign slot    = any_empty ? empty_idx : ring_q;
	assign abs_off = sample.sample_offset[TIME_W-1] ? (~sample.sample_offset + 1'b1)
	                                                : sample.sample_offset;
	assign reject  = (CMP_W'(fill_q) >= CMP_W'(sync_lim_q)) &&
	                 ({1'b0, abs_off} > {2'b00, err_lim_q});
	assign rej_inc = (rej_q == REJECT_MAX) ? rej_q : rej_q + 1'b1;
	assign sync_now = CMP_W'(fill_q) >= CMP_W'(sync_lim_q);

	assign ram_we    = accept_item && !reject;
	assign ram_wdata = '{stamp: sample.sample_local_time, offset: sample.sample_offset};

	csrt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot),
		.wdata(ram_wdata),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	// two mean dividers run side by side: local time and offset
	csrt_div #(.NUM_W(TIME_W), .DEN_W(N_W), .Q_W(TIME_W)) u_div_t (
		.clk(clk), .arst_n(arst_n), .start(div_go_q), .num(num_t_q), .den(fill_q),
		.done(div_done), .quot(qt_div), .ovf(), .rem(rt_div)
	);

	csrt_div #(.NUM_W(TIME_W), .DEN_W(N_W), .Q_W(TIME_W)) u_div_o (
		.clk(clk), .arst_n(arst_n), .start(div_go_q), .num(num_o_q), .den(fill_q),
		.done(), .quot(qo_div), .ovf(), .rem(ro_div)
	);

	// slope divider: |Sxy| * 2^30 / Sxx
	csrt_div #(.NUM_W(SN_W), .DEN_W(ACC_W), .Q_W(TIME_W)) u_div_s (
		.clk(clk), .arst_n(arst_n), .start(sdiv_go_q), .num(snum_q), .den(sxx_q),
		.done(sdiv_done), .quot(sq), .ovf(sovf), .rem()
	);

	assign dt      = ram_rdata.stamp - ref_t_q;
	assign dof     = ram_rdata.offset - ref_o_q;
	assign mul_y   = (state_q == S_W2_MA) ? a_q : b_q;
	assign sxy_mag = sxy_q[ACC_W-1] ? ACC_W'(-sxy_q) : ACC_W'(sxy_q);

	// remainder sums including the deviation that just finished dividing
	assign rt_fin = (state_q == S_W1_DIV)
	              ? rt_q + (neg_t_q ? -TIME_W'(rt_div) : TIME_W'(rt_div)) : rt_q;
	assign ro_fin = (state_q == S_W1_DIV)
	              ? ro_q + (neg_o_q ? -TIME_W'(ro_div) : TIME_W'(ro_div)) : ro_q;

	// saturate the scaled quotient to the int32 range
	always_comb begin
		if (sxy_neg_q) begin
			skew_val = (sovf || sq[TIME_W-1]) ? SKEW_NEG_MAX : (~sq + 1'b1);
		end else begin
			skew_val = (sovf || sq[TIME_W-1]) ? SKEW_POS_MAX : sq;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_lim_q     <= RST_ERROR_LIMIT;
			err_cnt_lim_q <= RST_ERROR_COUNT_LIMIT;
			sync_lim_q    <= RST_SYNC_ENTRY_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ERROR_LIMIT:       err_lim_q     <= cfg_wdata;
				CFG_ERROR_COUNT_LIMIT: err_cnt_lim_q <= cfg_wdata[CNTLIM_W-1:0];
				CFG_SYNC_ENTRY_LIMIT:  sync_lim_q    <= cfg_wdata[CNTLIM_W-1:0];
				default: ;
			endcase
		end
	end

	// shared multiplier, registered
	always_ff @(posedge clk) begin
		prod_s1 <= a_q * mul_y;
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			full_q    <= '0;
			fill_q    <= '0;
			ring_q    <= '0;
			rej_q     <= '0;
			held_q    <= '0;
			done_q    <= 1'b0;
			idx_q     <= '0;
			addr_q    <= '0;
			acc_q     <= 1'b0;
			clr_q     <= 1'b0;
			div_go_q  <= 1'b0;
			sdiv_go_q <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			div_go_q  <= 1'b0;
			sdiv_go_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						acc_q <= !reject;
						clr_q <= 1'b0;
						if (reject) begin
							// count the outlier; drop the table after too many
							rej_q <= rej_inc;
							if (rej_inc > err_cnt_lim_q) begin
								full_q <= '0;
								fill_q <= '0;
								clr_q  <= 1'b1;
							end
						end else begin
							rej_q        <= '0;
							full_q[slot] <= 1'b1;
							ring_q       <= (slot == LAST) ? '0 : slot + 1'b1;
							if (fill_q != N_W'(TABLE_SLOTS)) begin
								fill_q <= fill_q + 1'b1;
							end
						end
						state_q <= S_REF;
					end
				end
				S_REF: begin
					addr_q  <= ref_idx;
					state_q <= (fill_q == '0) ? S_SKEW : S_REF_W;
				end
				S_REF_W: state_q <= S_REF_L;
				S_REF_L: begin
					idx_q   <= '0;
					state_q <= S_W1_SEL;
				end
				S_W1_SEL: begin
					addr_q <= idx_q;
					if (full_q[idx_q]) begin
						state_q <= S_W1_W;
					end else if (last) begin
						div_go_q <= 1'b1;
						state_q  <= S_MEAN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_W1_W: state_q <= S_W1_L;
				S_W1_L: begin
					div_go_q <= 1'b1;
					state_q  <= S_W1_DIV;
				end
				S_W1_DIV: begin
					if (div_done) begin
						if (last) begin
							div_go_q <= 1'b1;
							state_q  <= S_MEAN;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_W1_SEL;
						end
					end
				end
				S_MEAN: begin
					if (div_done) begin
						idx_q   <= '0;
						state_q <= S_W2_SEL;
					end
				end
				S_W2_SEL: begin
					addr_q <= idx_q;
					if (full_q[idx_q]) begin
						state_q <= S_W2_W;
					end else if (last) begin
						state_q <= S_SLOPE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_W2_W:  state_q <= S_W2_L;
				S_W2_L:  state_q <= S_W2_MA;
				S_W2_MA: state_q <= S_W2_MB;
				S_W2_MB: state_q <= S_W2_ACC;
				S_W2_ACC: begin
					if (last) begin
						state_q <= S_SLOPE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_W2_SEL;
					end
				end
				S_SLOPE: begin
					// sums are final here; skip the divider on zero spread
					if (sxx_q != '0) begin
						sdiv_go_q <= 1'b1;
						state_q   <= S_SDIV;
					end else begin
						state_q <= S_SKEW;
					end
				end
				S_SDIV: begin
					if (sdiv_done) begin
						state_q <= S_SKEW;
					end
				end
				S_SKEW: begin
					if (fill_q != '0 && sxx_q != '0) begin
						held_q <= skew_val;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_REF_L: begin
				ref_t_q <= ram_rdata.stamp;
				ref_o_q <= ram_rdata.offset;
				qt_q    <= '0;
				qo_q    <= '0;
				rt_q    <= '0;
				ro_q    <= '0;
			end
			S_W1_L: begin
				// split each deviation into magnitude and sign, trunc toward zero
				neg_t_q <= dt[TIME_W-1];
				neg_o_q <= dof[TIME_W-1];
				num_t_q <= dt[TIME_W-1] ? (~dt + 1'b1) : dt;
				num_o_q <= dof[TIME_W-1] ? (~dof + 1'b1) : dof;
			end
			S_W1_DIV: begin
				if (div_done) begin
					qt_q <= qt_q + (neg_t_q ? (~qt_div + 1'b1) : qt_div);
					qo_q <= qo_q + (neg_o_q ? (~qo_div + 1'b1) : qo_div);
					rt_q <= rt_fin;
					ro_q <= ro_fin;
				end
			end
			default: ;
		endcase
		// remainder sums feed the final mean division
		if ((state_q == S_W1_SEL && !full_q[idx_q] && last) ||
		    (state_q == S_W1_DIV && div_done && last)) begin
			neg_t_q <= rt_fin[TIME_W-1];
			neg_o_q <= ro_fin[TIME_W-1];
			num_t_q <= rt_fin[TIME_W-1] ? (~rt_fin + 1'b1) : rt_fin;
			num_o_q <= ro_fin[TIME_W-1] ? (~ro_fin + 1'b1) : ro_fin;
		end
		if (state_q == S_MEAN && div_done) begin
			mean_t_q <= ref_t_q + qt_q + (neg_t_q ? (~qt_div + 1'b1) : qt_div);
			mean_o_q <= ref_o_q + qo_q + (neg_o_q ? (~qo_div + 1'b1) : qo_div);
			sxx_q    <= '0;
			sxy_q    <= '0;
		end
		if (state_q == S_W2_L) begin
			a_q <= ram_rdata.stamp - mean_t_q;
			b_q <= ram_rdata.offset - mean_o_q;
		end
		if (state_q == S_W2_MB) begin
			sxx_q <= sxx_q + ACC_W'($unsigned(prod_s1));
		end
		if (state_q == S_W2_ACC) begin
			sxy_q <= sxy_q + ACC_W'(prod_s1);
		end
		if (state_q == S_SLOPE) begin
			sxy_neg_q <= sxy_q[ACC_W-1];
			snum_q    <= {sxy_mag, FRAC_W'(0)};
		end
		if (state_q == S_SKEW) begin
			result_q.sample_accepted <= acc_q;
			result_q.table_cleared   <= clr_q;
			result_q.stored_entries  <= 4'(fill_q);
			result_q.synchronized    <= sync_now;
			result_q.estimate_valid  <= (fill_q != '0);
			result_q.skew_estimate   <= (fill_q != '0 && sxx_q != '0) ? skew_val : held_q;
			result_q.mean_offset     <= (fill_q != '0) ? mean_o_q : '0;
			result_q.mean_local_time <= (fill_q != '0) ? mean_t_q : '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item accepted but block not busy");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= N_W'(TABLE_SLOTS))
		else $error("fill count beyond table size");

	a_empty_means: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.estimate_valid |-> result.mean_offset == '0 &&
		result.mean_local_time == '0)
		else $error("empty table gave nonzero means");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");
`endif

endmodule
